// ----- rtl/fpp_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the framed packet parser.
// Depends on nothing; used by fpp_frame and framed_packet_parser_crc8.
package fpp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 12;
  localparam int unsigned IDX_W = 4;

  localparam logic [7:0] DEFAULT_MARKER = 8'hA5;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  typedef struct packed {
    logic        hit;
    logic [31:0] msg_id;
    logic [31:0] value_one;
    logic [31:0] value_two;
  } frame_res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/framed_packet_parser_crc8.sv -----
// Top level of the start-marker framed packet parser with CRC-8 check.
// Depends on fpp_pkg and fpp_frame.
// One received byte is taken per request and the block accepts a request in every cycle
// while the result side is not stalled. A byte passes through an input register and the
// frame logic to the result register, from which the result of a good frame is offered
// after its check byte. A frame is the start marker, twelve payload bytes and a CRC-8 byte
// (polynomial 0x07, initial value zero, over marker and payload); a good frame yields one
// result with three little-endian words, a bad one yields nothing. The marker register
// resets to 0xA5 and should be written only while the block is idle.
module framed_packet_parser_crc8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_msg_id,
  output logic [31:0] out_value_one,
  output logic [31:0] out_value_two
);

  logic [7:0]          marker_r;
  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                out_vld_r;
  logic [31:0]         msg_id_r, value_one_r, value_two_r;
  logic                advance;
  fpp_pkg::frame_res_t res;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= fpp_pkg::DEFAULT_MARKER;
    end else if (cfg_wr_en) begin
      marker_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  fpp_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .rx_byte      (in_byte_r),
    .start_marker (marker_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res.hit;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      msg_id_r    <= res.msg_id;
      value_one_r <= res.value_one;
      value_two_r <= res.value_two;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_msg_id    = msg_id_r;
  assign out_value_one = value_one_r;
  assign out_value_two = value_two_r;

`ifndef SYNTHESIS
  a_hit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.hit |=> out_vld_r)
    else $error("Matched frame did not produce a result.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("Input stalled while the pipeline could move.");

  a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(advance))
    else $error("Result appeared without a processed request.");
`endif

endmodule

// ----- rtl/fpp_frame.sv -----
// Frame tracker: phase, payload count, running CRC-8 and the payload shift line.
// Depends on fpp_pkg for phase codes, the result struct and crc8_step.
module fpp_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         start_marker,
  output fpp_pkg::frame_res_t res
);

  logic [1:0]                     phase_r, phase_nxt;
  logic [fpp_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [7:0]                     crc_r, crc_nxt;
  logic [7:0]                     store_r [fpp_pkg::PAYLOAD_BYTES];
  logic                           shift_en;
  logic                           hit;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    shift_en  = 1'b0;
    hit       = 1'b0;
    unique case (phase_r)
      fpp_pkg::PH_PAYLOAD: begin
        shift_en = 1'b1;
        crc_nxt  = fpp_pkg::crc8_step(crc_r, rx_byte);
        idx_nxt  = idx_r + 1'b1;
        if (idx_nxt == fpp_pkg::IDX_W'(fpp_pkg::PAYLOAD_BYTES)) begin
          phase_nxt = fpp_pkg::PH_CHECK;
        end
      end
      fpp_pkg::PH_CHECK: begin
        phase_nxt = fpp_pkg::PH_IDLE;
        hit       = (rx_byte == crc_r);
      end
      default: begin
        phase_nxt = fpp_pkg::PH_IDLE;
        if (rx_byte == start_marker) begin
          idx_nxt   = '0;
          crc_nxt   = fpp_pkg::crc8_step(8'h00, rx_byte);
          phase_nxt = fpp_pkg::PH_PAYLOAD;
        end
      end
    endcase
  end

  assign res.hit       = hit;
  assign res.msg_id    = {store_r[3], store_r[2], store_r[1], store_r[0]};
  assign res.value_one = {store_r[7], store_r[6], store_r[5], store_r[4]};
  assign res.value_two = {store_r[11], store_r[10], store_r[9], store_r[8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpp_pkg::PH_IDLE;
      idx_r   <= '0;
      crc_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // The oldest payload byte ends up in entry 0 after twelve shifts.
  always_ff @(posedge clk) begin
    if (step_en && shift_en) begin
      for (int i = 0; i < fpp_pkg::PAYLOAD_BYTES - 1; i++) begin
        store_r[i] <= store_r[i+1];
      end
      store_r[fpp_pkg::PAYLOAD_BYTES-1] <= rx_byte;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Testbench for framed_packet_parser_crc8: directed frames, then random framed traffic.
// Uses fpp_pkg for constants; checks every result against a local frame decoder or a listed known frame.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_FRAMES = 20;

  typedef struct packed {
    logic [31:0] msg_id;
    logic [31:0] value_one;
    logic [31:0] value_two;
  } frame_t;

  typedef enum logic [2:0] {ROW_RAW, ROW_MARK, ROW_DATA, ROW_GOOD, ROW_BAD} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] val;
    bit         known;
    frame_t     frame;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_msg_id;
  logic [31:0] out_value_one;
  logic [31:0] out_value_two;

  framed_packet_parser_crc8 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_msg_id   (out_msg_id),
    .out_value_one(out_value_one),
    .out_value_two(out_value_two)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder state, mirrored from the block.
  logic [1:0] fr_phase = fpp_pkg::PH_IDLE;
  logic [3:0] fr_count = '0;
  logic [7:0] fr_crc = '0;
  logic [7:0] fr_marker = fpp_pkg::DEFAULT_MARKER;
  logic [7:0] fr_bytes [fpp_pkg::PAYLOAD_BYTES];

  frame_t frames_due[$];
  frame_t known_frames[$];
  row_t   rows[$];

  int mismatches = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  logic [7:0] marker_now = fpp_pkg::DEFAULT_MARKER;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? fpp_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    frame_t f;
    case (fr_phase)
      fpp_pkg::PH_PAYLOAD: begin
        fr_bytes[fr_count] = b;
        fr_crc = crc8_next(fr_crc, b);
        fr_count = fr_count + 4'd1;
        if (fr_count >= fpp_pkg::PAYLOAD_BYTES) fr_phase = fpp_pkg::PH_CHECK;
      end
      fpp_pkg::PH_CHECK: begin
        fr_phase = fpp_pkg::PH_IDLE;
        if (b == fr_crc) begin
          f.msg_id    = {fr_bytes[3], fr_bytes[2], fr_bytes[1], fr_bytes[0]};
          f.value_one = {fr_bytes[7], fr_bytes[6], fr_bytes[5], fr_bytes[4]};
          f.value_two = {fr_bytes[11], fr_bytes[10], fr_bytes[9], fr_bytes[8]};
          if (known_frames.size() != 0) f = known_frames.pop_front();
          frames_due.push_back(f);
        end
      end
      default: begin
        fr_phase = fpp_pkg::PH_IDLE;
        if (b == fr_marker) begin
          fr_count = '0;
          fr_crc = crc8_next(8'h00, b);
          fr_phase = fpp_pkg::PH_PAYLOAD;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $error("msg_id: expected no result, got %h", out_msg_id);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("msg_id", want.msg_id, out_msg_id);
          check_field("value_one", want.value_one, out_value_one);
          check_field("value_two", want.value_two, out_value_two);
        end
      end
      if (in_valid && !in_stall) decode_byte(in_rx_byte);
      if (cfg_wr_en) fr_marker = cfg_wr_data;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input bit good);
    logic [7:0] acc;
    logic [7:0] b;
    acc = crc8_next(8'h00, marker_now);
    send_byte(marker_now);
    repeat (fpp_pkg::PAYLOAD_BYTES) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = marker_now;
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
      acc = crc8_next(acc, b);
      send_byte(b);
    end
    send_byte(good ? acc : acc ^ 8'($urandom_range(255, 1)));
  endtask

  // Enough non-marker bytes to carry any open frame back to idle.
  task automatic flush_frame();
    logic [7:0] b;
    repeat (fpp_pkg::PAYLOAD_BYTES + 2) begin
      b = 8'($urandom_range(255));
      if (b == marker_now) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_marker(input logic [7:0] m);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    marker_now = m;
  endtask

  task automatic run_traffic(input int n_frames);
    int pick;
    repeat (n_frames) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame($urandom_range(9) != 0);
      end else if (pick < 88) begin
        send_byte(marker_now);
        repeat ($urandom_range(11)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    flush_frame();
  endtask

  task automatic add_row(input row_kind_t kind, input logic [7:0] val);
    row_t r;
    r.kind = kind;
    r.val = val;
    r.known = 1'b0;
    r.frame = '0;
    rows.push_back(r);
  endtask

  initial begin
    logic [7:0] acc;
    logic [7:0] b;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;

    // Idle noise at both extremes, a good frame with the marker and extremes
    // inside the payload, then an all-ones frame with a corrupted check byte.
    add_row(ROW_RAW, 8'h00);
    add_row(ROW_RAW, 8'hFF);
    add_row(ROW_MARK, fpp_pkg::DEFAULT_MARKER);
    add_row(ROW_DATA, 8'hA5);
    add_row(ROW_DATA, 8'hFF);
    for (int i = 0; i < 9; i++) add_row(ROW_DATA, 8'(i));
    add_row(ROW_DATA, 8'hA5);
    add_row(ROW_GOOD, 8'h00);
    rows[rows.size() - 1].known = 1'b1;
    rows[rows.size() - 1].frame = '{msg_id: 32'h0100FFA5, value_one: 32'h05040302,
                                    value_two: 32'hA5080706};
    add_row(ROW_MARK, fpp_pkg::DEFAULT_MARKER);
    repeat (fpp_pkg::PAYLOAD_BYTES) add_row(ROW_DATA, 8'hFF);
    add_row(ROW_BAD, 8'h01);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    acc = 8'h00;
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_GOOD: b = acc;
        ROW_BAD:  b = acc ^ rows[i].val;
        default:  b = rows[i].val;
      endcase
      if (rows[i].kind == ROW_MARK) acc = crc8_next(8'h00, b);
      if (rows[i].kind == ROW_DATA) acc = crc8_next(acc, b);
      if (rows[i].known) known_frames.push_back(rows[i].frame);
      send_byte(b);
    end

    set_marker(8'h00);
    run_traffic(PHASE_FRAMES);

    set_marker(8'hFF);
    gap_pct = 61;
    run_traffic(PHASE_FRAMES);

    set_marker(8'($urandom_range(255)));
    gap_pct = 0;
    stall_pct = 61;
    run_traffic(PHASE_FRAMES);

    set_marker(8'($urandom_range(255)));
    gap_pct = 12;
    stall_pct = 12;
    run_traffic(PHASE_FRAMES);

    // The receiver holds off while frames keep arriving back to back.
    set_marker(fpp_pkg::DEFAULT_MARKER);
    gap_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    run_traffic(PHASE_FRAMES);

    wait_quiet();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- framed_packet_parser_crc8.f -----
rtl/fpp_pkg.sv
rtl/fpp_frame.sv
rtl/framed_packet_parser_crc8.sv
verif/tb.sv
